// ===== sv/bde_pkg.sv =====
// Shared types and constants for the B-spline de Boor evaluator.
package bde_pkg;

  localparam int unsigned ONE_Q16  = 65536;
  localparam int unsigned ROUND_Q16 = 32768;

  localparam logic [0:0] CFG_DEGREE = 1'b0;
  localparam logic [0:0] CFG_COUNT  = 1'b1;

  localparam logic [2:0] DEGREE_RST = 3'd2;
  localparam logic [4:0] COUNT_RST  = 5'd4;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_EVAL = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_COPY_RD,
    ST_COPY_WR,
    ST_WEIGHT,
    ST_DIV,
    ST_RD_LO,
    ST_RD_HI,
    ST_RD_CAP,
    ST_MUL,
    ST_WR,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic done;
  } div_ctl_t;

endpackage

// ===== sv/bde_ifs.sv =====
// Valid/ready channel interfaces for load/evaluate words and result words.
interface bde_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [3:0]  point_index;
  logic signed [31:0] coord_x;
  logic signed [31:0] coord_y;
  logic signed [31:0] coord_z;
  logic [16:0] param_u;
  modport source (output valid, kind, point_index, coord_x, coord_y, coord_z, param_u,
                  input ready);
  modport sink   (input valid, kind, point_index, coord_x, coord_y, coord_z, param_u,
                  output ready);
endinterface

interface bde_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  logic        valid_res;
  modport source (output valid, point_x, point_y, point_z, valid_res, input ready);
  modport sink   (input valid, point_x, point_y, point_z, valid_res, output ready);
endinterface

// ===== sv/bde_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module bde_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wen,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

// ===== sv/bde_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
module bde_div #(
  parameter int NW = 21,
  parameter int MW = 5
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bde_pkg::div_ctl_t     ctl_i,
  output logic                  done_o,
  input  logic [NW-1:0]         dividend,
  input  logic [MW-1:0]         divisor,
  output logic [NW-1:0]         quotient
);
  import bde_pkg::*;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] quo_r, quo_nxt;
  logic [MW-1:0] rem_r, rem_nxt;
  logic [MW-1:0] dvs_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          done_r, done_nxt;
  logic [MW:0]   sh;
  logic [MW:0]   diff;

  always_comb begin
    sh       = {rem_r, quo_r[NW-1]};
    diff     = sh - {1'b0, dvs_r};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (ctl_i.start) begin
      quo_nxt = dividend;
      rem_nxt = '0;
      cnt_nxt = CW'(NW);
    end else if (cnt_r != '0) begin
      if (sh >= {1'b0, dvs_r}) begin
        rem_nxt = diff[MW-1:0];
        quo_nxt = {quo_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = sh[MW-1:0];
        quo_nxt = {quo_r[NW-2:0], 1'b0};
      end
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (ctl_i.start) begin
      dvs_r <= divisor;
    end
  end

  assign done_o   = done_r;
  assign quotient = quo_r;
endmodule

// ===== sv/bspline_de_boor_eval.sv =====
// Top level: clamped uniform B-spline point evaluator using de Boor's scheme.
//
//  channel  | dir | handshake          | contents
//  in_word  | in  | valid/ready        | kind, point_index, coord_x/y/z, param_u
//  out_word | out | valid/ready        | point_x/y/z, valid_res
//  cfg_*    | in  | APB, pready high   | degree @0x0, point_count @0x4
//
// A load word is written straight into the point store. An evaluate word copies
// d+1 points into the blend store, then computes d(d+1)/2 blends, each with a
// 16+clog2(MAX_POINTS+1)-bit quotient divider for the weight (skipped when the
// weight is zero), two reads of the blend store and a shared 32x18 multiplier
// over six products.
// Input is taken only while the sequencer is idle; a finished result waits in
// the output register, and the sequencer holds the next one until it drains.
// Synchronous reset clears control state only; stores are undefined until written.
module bspline_de_boor_eval #(
  parameter int MAX_POINTS = 16,
  parameter int MAX_DEGREE = 7
) (
  input  logic        clk,
  input  logic        rst_n,
  bde_in_if.sink      in_word,
  bde_out_if.source   out_word,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import bde_pkg::*;

  localparam int MW  = $clog2(MAX_POINTS + 1);
  localparam int NW  = 16 + MW;
  localparam int CAW = $clog2(MAX_POINTS);
  localparam int WAW = $clog2(MAX_DEGREE + 1);
  localparam int IW0 = $clog2(MAX_POINTS + 2 * MAX_DEGREE + 2);
  localparam int IW  = (IW0 < 5) ? 5 : IW0;

  // configuration
  logic [2:0] degree_r;
  logic [4:0] count_r;
  logic       cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      degree_r <= DEGREE_RST;
      count_r  <= COUNT_RST;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == CFG_DEGREE) begin
        degree_r <= cfg_pwdata[2:0];
      end else begin
        count_r <= cfg_pwdata[4:0];
      end
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == CFG_DEGREE) ? {29'd0, degree_r} : {27'd0, count_r};

  // sequencer state
  state_t        state_r, state_nxt;
  logic [IW-1:0] d_r, n_r, m_r, my_r, i_r, k_r;
  logic [15:0]   p_r;
  logic [NW-1:0] num_r;
  logic [15:0]   w_r;
  logic [95:0]   lo_r, hi_r;
  logic [2:0]    s_r;
  logic signed [49:0] prod_r;
  logic signed [51:0] acc_r;
  logic [31:0]   blend_r [3];
  logic [31:0]   res_r [3];
  logic          res_ok_r;
  logic          out_valid_r;
  logic [31:0]   out_x_r, out_y_r, out_z_r;
  logic          out_ok_r;

  logic          in_acc, out_free;
  logic [IW-1:0] d_in, n_in, slot_ext;
  logic [NW-1:0] num_in;

  assign in_word.ready = (state_r == ST_IDLE);
  assign in_acc        = in_word.valid && in_word.ready;
  assign out_free      = !out_valid_r || out_word.ready;

  always_comb begin
    d_in = (int'(degree_r) > MAX_DEGREE) ? IW'(MAX_DEGREE) : IW'(degree_r);
    n_in = (int'(count_r) > MAX_POINTS) ? IW'(MAX_POINTS) : IW'(count_r);
    slot_ext = IW'(in_word.point_index);
    num_in = NW'(in_word.param_u[15:0]) * NW'(n_in - d_in);
  end

  function automatic logic [IW-1:0] knot_num(input logic [IW-1:0] x, input logic [IW-1:0] d,
                                             input logic [IW-1:0] n);
    logic [IW-1:0] r;
    if (x <= d) r = '0;
    else if (x >= n) r = n - d;
    else r = x - d;
    return r;
  endfunction

  // weight terms
  logic [IW-1:0] j_w, kj, kk, src;
  logic [NW-1:0] base, diff_w;
  logic          div_need;
  always_comb begin
    j_w      = my_r - k_r + IW'(1) + i_r;
    kj       = knot_num(j_w, d_r, n_r);
    kk       = knot_num(j_w + k_r, d_r, n_r);
    base     = {kj[MW-1:0], 16'd0};
    diff_w   = num_r - base;
    div_need = (kk > kj) && (num_r >= base);
    src      = my_r - d_r + i_r;
    if (src >= IW'(MAX_POINTS)) src = IW'(MAX_POINTS - 1);
  end

  // divider
  div_ctl_t      div_ctl;
  logic          div_done;
  logic [NW-1:0] div_q;
  logic [IW-1:0] kdiff;
  assign kdiff = kk - kj;

  bde_div #(.NW(NW), .MW(MW)) u_div (
    .clk(clk), .rst_n(rst_n), .ctl_i(div_ctl), .done_o(div_done),
    .dividend(diff_w), .divisor(kdiff[MW-1:0]), .quotient(div_q)
  );

  // memories
  logic           cp_wen, wk_wen;
  logic [CAW-1:0] cp_raddr;
  logic [WAW-1:0] wk_waddr, wk_raddr;
  logic [95:0]    cp_rdata, wk_wdata, wk_rdata;

  bde_ram #(.WIDTH(96), .DEPTH(MAX_POINTS)) u_cp_ram (
    .clk(clk), .wen(cp_wen), .waddr(slot_ext[CAW-1:0]),
    .wdata({in_word.coord_z, in_word.coord_y, in_word.coord_x}),
    .raddr(cp_raddr), .rdata(cp_rdata)
  );

  bde_ram #(.WIDTH(96), .DEPTH(MAX_DEGREE + 1)) u_wk_ram (
    .clk(clk), .wen(wk_wen), .waddr(wk_waddr), .wdata(wk_wdata),
    .raddr(wk_raddr), .rdata(wk_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && in_word.kind == KIND_EVAL) begin
          if (in_word.param_u[16] || n_in <= d_in) state_nxt = ST_DONE;
          else state_nxt = ST_COPY_RD;
        end
      end
      ST_COPY_RD: state_nxt = ST_COPY_WR;
      ST_COPY_WR: begin
        if (i_r != d_r) state_nxt = ST_COPY_RD;
        else if (d_r == '0) state_nxt = ST_DONE;
        else state_nxt = ST_WEIGHT;
      end
      ST_WEIGHT: state_nxt = div_need ? ST_DIV : ST_RD_LO;
      ST_DIV:    if (div_done) state_nxt = ST_RD_LO;
      ST_RD_LO:  state_nxt = ST_RD_HI;
      ST_RD_HI:  state_nxt = ST_RD_CAP;
      ST_RD_CAP: state_nxt = ST_MUL;
      ST_MUL:    if (s_r == 3'd6) state_nxt = ST_WR;
      ST_WR: begin
        if (i_r + IW'(1) < k_r || k_r != IW'(1)) state_nxt = ST_WEIGHT;
        else state_nxt = ST_DONE;
      end
      ST_DONE:   if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    cp_wen        = in_acc && in_word.kind == KIND_LOAD && int'(in_word.point_index) < MAX_POINTS;
    cp_raddr      = src[CAW-1:0];
    wk_wen        = (state_r == ST_COPY_WR) || (state_r == ST_WR);
    wk_waddr      = i_r[WAW-1:0];
    wk_wdata      = (state_r == ST_COPY_WR) ? cp_rdata : {blend_r[2], blend_r[1], blend_r[0]};
    wk_raddr      = (state_r == ST_RD_HI) ? WAW'(i_r + IW'(1)) : i_r[WAW-1:0];
    div_ctl.start = (state_r == ST_WEIGHT) && div_need;
    div_ctl.done  = 1'b0;
  end

  // blend arithmetic
  logic [1:0]          coord;
  logic signed [31:0]  mul_a;
  logic signed [17:0]  mul_b;
  logic [16:0]         w_inv;
  logic signed [51:0]  tot;
  logic signed [35:0]  q;
  logic [31:0]         q_sat;
  logic [1:0]          done_c;
  always_comb begin
    coord  = 2'(s_r >> 1);
    w_inv  = 17'(ONE_Q16) - {1'b0, w_r};
    mul_a  = s_r[0] ? $signed(hi_r[32*coord +: 32]) : $signed(lo_r[32*coord +: 32]);
    mul_b  = s_r[0] ? $signed({2'b00, w_r}) : $signed({1'b0, w_inv});
    tot    = acc_r + 52'(prod_r) + 52'(ROUND_Q16);
    q      = tot[51:16];
    if (q > 36'sd2147483647) q_sat = 32'h7fffffff;
    else if (q < -36'sd2147483648) q_sat = 32'h80000000;
    else q_sat = q[31:0];
    done_c = 2'((s_r - 3'd1) >> 1);
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_DONE && out_free) out_valid_r <= 1'b1;
      else if (out_word.ready) out_valid_r <= 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        d_r      <= d_in;
        n_r      <= n_in;
        m_r      <= n_in - d_in;
        p_r      <= in_word.param_u[15:0];
        num_r    <= num_in;
        my_r     <= d_in + IW'(num_in[NW-1:16]);
        i_r      <= '0;
        res_ok_r <= !(in_word.param_u[16] || n_in <= d_in);
        for (int c = 0; c < 3; c++) res_r[c] <= '0;
      end
      ST_COPY_WR: begin
        for (int c = 0; c < 3; c++) res_r[c] <= cp_rdata[32*c +: 32];
        if (i_r != d_r) i_r <= i_r + IW'(1);
        else begin
          i_r <= '0;
          k_r <= d_r;
        end
      end
      ST_WEIGHT: if (!div_need) w_r <= '0;
      ST_DIV: begin
        if (div_done) w_r <= (div_q > NW'(16'hffff)) ? 16'hffff : div_q[15:0];
      end
      ST_RD_HI:  lo_r <= wk_rdata;
      ST_RD_CAP: begin
        hi_r <= wk_rdata;
        s_r  <= '0;
      end
      ST_MUL: begin
        prod_r <= mul_a * mul_b;
        if (s_r != 3'd0) begin
          if (!s_r[0]) blend_r[done_c] <= q_sat;
          else acc_r <= 52'(prod_r);
        end
        s_r <= s_r + 3'd1;
      end
      ST_WR: begin
        for (int c = 0; c < 3; c++) res_r[c] <= blend_r[c];
        if (i_r + IW'(1) < k_r) i_r <= i_r + IW'(1);
        else begin
          i_r <= '0;
          k_r <= k_r - IW'(1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_x_r  <= res_r[0];
          out_y_r  <= res_r[1];
          out_z_r  <= res_r[2];
          out_ok_r <= res_ok_r;
        end
      end
      default: ;
    endcase
  end

  assign out_word.valid     = out_valid_r;
  assign out_word.point_x   = out_x_r;
  assign out_word.point_y   = out_y_r;
  assign out_word.point_z   = out_z_r;
  assign out_word.valid_res = out_ok_r;

  // unused in datapath beyond latch; keeps point span visible for debug
  logic [IW-1:0] span_dbg;
  assign span_dbg = m_r + IW'(p_r[0]);

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && !res_ok_r) |-> (res_r[0] == '0 && res_r[1] == '0 && res_r[2] == '0))
    else $error("invalid result carries nonzero point");

  a_wr_in_level: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WR) |-> (i_r < k_r && k_r <= d_r && span_dbg >= m_r))
    else $error("blend write outside current level");

  a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_ctl.start |=> (state_r == ST_DIV))
    else $error("divider started outside weight step");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && !out_free) |=> $stable(out_x_r))
    else $error("result overwritten while waiting");
endmodule
